// ===== design/svdp_pkg.sv =====
// Package for the SVD projection engine: widths, limits, codes, payload types.
// No dependencies.
package svdp_pkg;
	localparam int MaxInputs = 64;
	localparam int MaxOrder = 16;
	localparam int RowW = $clog2(MaxInputs);
	localparam int ColW = $clog2(MaxOrder);
	localparam int CntW = $clog2(MaxInputs + 2);
	localparam int AccW = 40;

	typedef enum logic [1:0] {
		FUNC_WEIGHT = 2'd0,
		FUNC_SINGULAR = 2'd1,
		FUNC_SAMPLE = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_LENGTH = 2'd1,
		ST_ZERO_DIV = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_INPUT_COUNT = 1'd0,
		REG_ORDER_IN_USE = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_MAC, S_DIV, S_EMIT, S_ERR
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] row_index;
		logic [3:0] column_index;
		logic signed [15:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [3:0] coefficient_index;
		logic signed [31:0] coefficient;
		logic end_of_run;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [6:0] index;
		logic [6:0] data;
	} cfg_item_t;

	// Control from sequencer to the cell row
	typedef struct packed {
		logic shift;
		logic mac;
		logic clear;
	} cell_ctl_t;
endpackage

// ===== design/svdp_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on svdp_pkg for payload types.
interface svdp_in_if (input logic clk);
	svdp_pkg::in_item_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svdp_out_if (input logic clk);
	svdp_pkg::out_item_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svdp_cfg_if (input logic clk);
	svdp_pkg::cfg_item_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/svdp_cell.sv =====
// One accumulator cell of the rotating chain: multiply-add or pass along.
// Depends on svdp_pkg.
module svdp_cell (
	input logic clk,
	input logic arst_n,
	input svdp_pkg::cell_ctl_t ctl,
	input logic signed [svdp_pkg::AccW-1:0] acc_in,
	input logic signed [15:0] weight,
	input logic signed [15:0] sample,
	output logic signed [svdp_pkg::AccW-1:0] acc_out
);
	import svdp_pkg::*;
	logic signed [31:0] prod;
	logic signed [AccW:0] sum;
	logic signed [AccW-1:0] nxt;
	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	// Add the product with 40-bit saturation
	always_comb begin
		prod = weight * sample;
		sum = {acc_in[AccW-1], acc_in} + {{(AccW-31){prod[31]}}, prod};
		if (sum[AccW] != sum[AccW-1])
			nxt = sum[AccW] ? AccMin : AccMax;
		else
			nxt = sum[AccW-1:0];
		if (!ctl.mac)
			nxt = acc_in;
	end

	// Clear, hold or take the value handed from the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_out <= '0;
		else if (ctl.clear)
			acc_out <= '0;
		else if (ctl.shift)
			acc_out <= nxt;
	end
endmodule

// ===== design/svdp_divider.sv =====
// Restoring divider: magnitude of a 40-bit accumulator over 64*s, one bit a cycle.
// Depends on svdp_pkg.
module svdp_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [svdp_pkg::AccW-1:0] acc,
	input logic [15:0] sv,
	output logic done,
	output logic signed [31:0] quot,
	output logic zero
);
	import svdp_pkg::*;
	logic [AccW-1:0] num_q;
	logic [AccW-1:0] rem_q;
	logic [21:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q, zero_q, nz_q;
	logic [AccW:0] trial;
	logic [AccW-1:0] rsh;

	assign rsh = {rem_q[AccW-2:0], num_q[AccW-1]};
	assign trial = {1'b0, rsh} - {{(AccW-21){1'b0}}, den_q};

	// Shift one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(AccW);
				neg_q <= acc[AccW-1];
				nz_q <= acc != '0;
				zero_q <= sv == 16'd0;
				num_q <= acc[AccW-1] ? AccW'(-acc) : acc;
				rem_q <= '0;
				den_q <= {sv, 6'd0};
			end else if (busy_q) begin
				if (!trial[AccW]) begin
					rem_q <= trial[AccW-1:0];
					num_q <= {num_q[AccW-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					num_q <= {num_q[AccW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Sign and saturate; num_q now holds the magnitude quotient
	always_comb begin
		zero = zero_q;
		if (zero_q)
			quot = !nz_q ? 32'sd0 : (neg_q ? 32'sh80000000 : 32'sh7FFFFFFF);
		else if (neg_q)
			quot = (num_q > 40'h80000000) ? 32'sh80000000 : 32'(-num_q);
		else
			quot = (num_q > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : num_q[31:0];
	end
endmodule

// ===== design/svd_projection_engine.sv =====
// Top level of the SVD projection engine: sequencer, weight memory, cell chain.
// Depends on svdp_pkg, svdp_if, svdp_cell, svdp_divider.
//
// Usage: input requests on in_ch are loads (weight, singular value) or sample
// elements; cfg_ch writes input_count (index 0) and order_in_use (index 1).
// A load is written as it is accepted. A sample element passes, before the
// next request, through the accept cycle and then a ring of 16 accumulator cells
// that rotates once per element while the weight memory port streams one
// weight per cycle into the head cell (a priming step plus 16 steps).
// After the last element, each coefficient rotates to the tail and goes
// through a one-bit-per-cycle divider (start, 40 bit steps, finish) before
// its result is registered. A wrong-length vector gives one error result.
// The result register holds while out_ch.ready is low and the block
// takes no new request until it drains. Reset clears the accumulators,
// element count and registers (input_count 64, order_in_use 16); the weight
// and singular stores are undefined until loaded.
module svd_projection_engine (
	input logic clk,
	input logic arst_n,
	svdp_in_if.sink in_ch,
	svdp_cfg_if.sink cfg_ch,
	svdp_out_if.source out_ch
);
	import svdp_pkg::*;

	logic [15:0] wmem [MaxInputs*MaxOrder];
	logic [15:0] smem [MaxOrder];
	logic [6:0] input_count_q;
	logic [4:0] order_q;
	state_t state_q, state_d;
	logic [CntW-1:0] count_q;
	logic [ColW:0] step_q;
	logic [ColW:0] ord_q;
	logic signed [15:0] sample_q;
	logic signed [15:0] wrd_q;
	logic last_q, pend_q;
	logic out_valid_q;
	out_item_t out_q;
	cell_ctl_t ctl;
	logic signed [AccW-1:0] ring [MaxOrder];
	logic div_start, div_done, div_zero;
	logic signed [31:0] div_q;
	logic [15:0] sv_q;
	logic accept, do_mac;
	logic [6:0] len;
	logic [ColW:0] ord_calc;

	assign accept = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	assign do_mac = count_q < CntW'(MaxInputs);

	// Clamp registers to their effective ranges
	always_comb begin
		len = (input_count_q == 7'd0) ? 7'd1 :
			(input_count_q > 7'(MaxInputs)) ? 7'(MaxInputs) : input_count_q;
		ord_calc = (order_q == 5'd0) ? (ColW+1)'(1) :
			(order_q > 5'(MaxOrder)) ? (ColW+1)'(MaxOrder) : order_q[ColW:0];
		if ({2'b0, ord_calc} > len)
			ord_calc = len[ColW:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q <= 7'd64;
			order_q <= 5'd16;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				7'(REG_INPUT_COUNT): input_count_q <= cfg_ch.data.data;
				7'(REG_ORDER_IN_USE): order_q <= cfg_ch.data.data[4:0];
				default: ;
			endcase
		end
	end

	// Weight and singular memories; weight read streams by column step
	always_ff @(posedge clk) begin
		if (accept && in_ch.data.func == FUNC_WEIGHT)
			wmem[{in_ch.data.row_index, in_ch.data.column_index}] <= in_ch.data.value;
		if (accept && in_ch.data.func == FUNC_SINGULAR)
			smem[in_ch.data.column_index] <= in_ch.data.value;
		wrd_q <= wmem[{count_q[RowW-1:0], step_q[ColW-1:0]}];
		sv_q <= smem[step_q[ColW-1:0]];
	end

	// Cell ring: head takes the tail's value
	for (genvar i = 0; i < MaxOrder; i++) begin : g_cell
		cell_ctl_t cell_ctl;
		assign cell_ctl.shift = ctl.shift;
		assign cell_ctl.mac = ctl.mac && (i == 0);
		assign cell_ctl.clear = ctl.clear;
		svdp_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl(cell_ctl),
			.acc_in(ring[(i + MaxOrder - 1) % MaxOrder]),
			.weight(wrd_q), .sample(sample_q),
			.acc_out(ring[i])
		);
	end

	svdp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.acc(ring[MaxOrder-1]), .sv(sv_q),
		.done(div_done), .quot(div_q), .zero(div_zero)
	);

	// Next state and cell controls
	always_comb begin
		state_d = state_q;
		ctl = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_ch.data.func == FUNC_SAMPLE)
					state_d = S_MAC;
			end
			S_MAC: begin
				// step 0 primes the weight read; steps 1..16 rotate the ring
				if (step_q != '0) begin
					ctl.shift = 1'b1;
					ctl.mac = do_mac;
				end
				if (step_q == (ColW+1)'(MaxOrder)) begin
					if (!last_q)
						state_d = S_IDLE;
					else if (count_q + CntW'(do_mac || count_q == CntW'(MaxInputs)) != len)
						state_d = S_ERR;
					else
						state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (!pend_q && !out_valid_q)
					div_start = 1'b1;
				if (div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q) begin
					ctl.shift = 1'b1;
					if (step_q + 1'b1 == ord_q) begin
						ctl.clear = 1'b1;
						state_d = S_IDLE;
					end else
						state_d = S_DIV;
				end
			end
			S_ERR: begin
				if (!out_valid_q) begin
					ctl.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q <= '0;
			last_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			ord_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (state_d == S_MAC) begin
						sample_q <= in_ch.data.value;
						last_q <= in_ch.data.last;
					end
				end
				S_MAC: begin
					if (state_d != S_MAC) begin
						if (count_q <= CntW'(MaxInputs))
							count_q <= count_q + 1'b1;
						step_q <= '0;
						ord_q <= ord_calc;
						pend_q <= 1'b0;
					end else
						step_q <= step_q + 1'b1;
				end
				S_DIV: begin
					if (div_start)
						pend_q <= 1'b1;
				end
				S_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q.coefficient_index <= step_q[ColW-1:0];
						out_q.coefficient <= div_q;
						out_q.status <= div_zero ? ST_ZERO_DIV : ST_OK;
						out_q.end_of_run <= step_q + 1'b1 == ord_q;
						pend_q <= 1'b0;
						step_q <= step_q + 1'b1;
						if (state_d == S_IDLE) begin
							count_q <= '0;
							step_q <= '0;
						end
					end
				end
				S_ERR: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q.coefficient_index <= '0;
						out_q.coefficient <= '0;
						out_q.end_of_run <= 1'b1;
						out_q.status <= ST_LENGTH;
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Ring rotation to the tail: ring holds accumulator (step) at index MaxOrder-1
	// after each full MAC pass since the head is fed from the tail.

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE) else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxInputs + 1)) else $error("count overflow");
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_LENGTH |-> out_q.end_of_run)
		else $error("error without end");
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for svd_projection_engine: directed table, then random vectors.
// Depends on svdp_pkg, svdp_if and the engine RTL.
module testbench;
	import svdp_pkg::*;

	logic clk;
	logic arst_n;
	int fail_count;

	svdp_in_if in_ch (clk);
	svdp_cfg_if cfg_ch (clk);
	svdp_out_if out_ch (clk);

	svd_projection_engine dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
	);

	// Shadow state of the engine
	logic signed [15:0] weight_shadow [MaxInputs][MaxOrder];
	logic [15:0] singular_shadow [MaxOrder];
	logic signed [39:0] acc_shadow [MaxOrder];
	int sample_count;
	int length_reg;
	int order_reg;
	bit weight_written [MaxInputs][MaxOrder];
	bit singular_written [MaxOrder];
	out_item_t coefficient_queue [$];

	// Directed table: item plus optional typed-in expected result
	typedef struct {
		in_item_t item;
		bit has_typed;
		out_item_t typed;
	} row_t;
	row_t stim_table [$];

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got, exp);
		$display("mismatch %s: got %0h expected %0h", what, got, exp);
		fail_count++;
	endtask

	function automatic logic signed [39:0] sat_acc(input logic signed [40:0] s);
		if (s > 41'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
		if (s < -41'sh80_0000_0000) return -40'sh80_0000_0000;
		return s[39:0];
	endfunction

	function automatic logic [31:0] scale_coefficient(input logic signed [39:0] acc,
			input logic [15:0] sv);
		logic [40:0] mag;
		logic [40:0] quot;
		if (sv == 0) begin
			if (acc > 0) return 32'h7FFF_FFFF;
			if (acc < 0) return 32'h8000_0000;
			return 32'h0;
		end
		mag = acc < 0 ? 41'(-$signed({acc[39], acc})) : 41'(acc);
		quot = mag / (41'(sv) * 41'd64);
		if (acc < 0) begin
			if (quot > 41'h8000_0000) quot = 41'h8000_0000;
			return 32'(-quot);
		end
		if (quot > 41'h7FFF_FFFF) quot = 41'h7FFF_FFFF;
		return quot[31:0];
	endfunction

	// Apply one request to the shadow state and queue its coefficients
	task automatic predict_projection(input in_item_t it);
		int len;
		int ord;
		out_item_t r;
		case (func_t'(it.func))
			FUNC_WEIGHT: begin
				weight_shadow[it.row_index][it.column_index] = it.value;
				weight_written[it.row_index][it.column_index] = 1;
			end
			FUNC_SINGULAR: begin
				singular_shadow[it.column_index] = it.value;
				singular_written[it.column_index] = 1;
			end
			FUNC_SAMPLE: begin
				if (sample_count < MaxInputs)
					for (int c = 0; c < MaxOrder; c++)
						acc_shadow[c] = sat_acc(41'(acc_shadow[c])
							+ 41'(weight_shadow[sample_count][c]) * 41'(it.value));
				if (sample_count <= MaxInputs) sample_count++;
				if (it.last) begin
					len = length_reg < 1 ? 1 : (length_reg > MaxInputs ? MaxInputs : length_reg);
					if (sample_count != len) begin
						r = '0;
						r.end_of_run = 1;
						r.status = ST_LENGTH;
						coefficient_queue.push_back(r);
					end else begin
						ord = order_reg > len ? len : order_reg;
						if (ord < 1) ord = 1;
						if (ord > MaxOrder) ord = MaxOrder;
						for (int c = 0; c < ord; c++) begin
							r.coefficient_index = 4'(c);
							r.coefficient = scale_coefficient(acc_shadow[c], singular_shadow[c]);
							r.end_of_run = (c + 1 == ord);
							r.status = singular_shadow[c] == 0 ? ST_ZERO_DIV : ST_OK;
							coefficient_queue.push_back(r);
						end
					end
					for (int c = 0; c < MaxOrder; c++) acc_shadow[c] = 0;
					sample_count = 0;
				end
			end
			default: ;
		endcase
	endtask

	// Send one request, with a random gap first on some bursts; valid stays
	// high between back-to-back requests and drops only for a gap
	int burst_left;
	task automatic send_request(input in_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_projection(it);
	endtask

	task automatic write_register(input reg_idx_t idx, input int val);
		in_ch.valid <= 1'b0;
		while (coefficient_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_ch.data <= '{index: 7'(idx), data: 7'(val)};
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_INPUT_COUNT) length_reg = val & 8'h7F;
		else order_reg = val & 5'h1F;
	endtask

	function automatic in_item_t make_item(func_t f, int row, int col, int val, bit lst);
		in_item_t it;
		it.func = f;
		it.row_index = 6'(row);
		it.column_index = 4'(col);
		it.value = 16'(val);
		it.last = lst;
		return it;
	endfunction

	// Load weight rows first_row..last_row-1, then every singular value
	task automatic load_all(input int first_row, input int last_row, input bit zero_sv);
		for (int r = first_row; r < last_row; r++)
			for (int c = 0; c < MaxOrder; c++)
				send_request(make_item(FUNC_WEIGHT, r, c, $urandom, $urandom_range(0, 1)));
		for (int c = 0; c < MaxOrder; c++)
			send_request(make_item(FUNC_SINGULAR, $urandom, c,
				zero_sv && $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
				$urandom_range(0, 1)));
	endtask

	// Send one vector; its length may be wrong on purpose
	task automatic send_vector(input int n);
		for (int i = 0; i < n; i++)
			send_request(make_item(FUNC_SAMPLE, $urandom, $urandom,
				$urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768) : $urandom,
				i == n - 1));
	endtask

	// Check each accepted coefficient against the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (coefficient_queue.size() == 0) begin
				report_mismatch("unexpected result", out_ch.data, 0);
			end else begin
				exp_r = coefficient_queue.pop_front();
				if (out_ch.data.coefficient_index !== exp_r.coefficient_index)
					report_mismatch("coefficient_index", out_ch.data.coefficient_index,
						exp_r.coefficient_index);
				if (out_ch.data.coefficient !== exp_r.coefficient)
					report_mismatch("coefficient", out_ch.data.coefficient, exp_r.coefficient);
				if (out_ch.data.end_of_run !== exp_r.end_of_run)
					report_mismatch("end_of_run", out_ch.data.end_of_run, exp_r.end_of_run);
				if (out_ch.data.status !== exp_r.status)
					report_mismatch("status", out_ch.data.status, exp_r.status);
			end
		end
	end

	// Stall the result side on a pattern of its own
	int stall_phase;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[9]) out_ch.ready <= 1'b1;
		else out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		#20_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		row_t rw;
		int sizes [4];
		out_item_t typed_got;
		fail_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		sample_count = 0;
		length_reg = 64;
		order_reg = 16;
		for (int c = 0; c < MaxOrder; c++) acc_shadow[c] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wrong lengths after reset, short vectors with extremes
		rw.has_typed = 1;
		rw.typed = '{coefficient_index: 0, coefficient: 0, end_of_run: 1, status: ST_LENGTH};
		rw.item = make_item(FUNC_SAMPLE, 0, 0, 0, 1);
		stim_table.push_back(rw);
		rw.item = make_item(FUNC_NONE, 63, 15, -1, 1);
		rw.has_typed = 0;
		stim_table.push_back(rw);
		foreach (stim_table[i]) begin
			send_request(stim_table[i].item);
			if (stim_table[i].has_typed) begin
				typed_got = coefficient_queue[$];
				if (typed_got !== stim_table[i].typed)
					report_mismatch("typed row", typed_got, stim_table[i].typed);
			end
		end
		write_register(REG_INPUT_COUNT, 2);
		write_register(REG_ORDER_IN_USE, 16);
		send_request(make_item(FUNC_WEIGHT, 0, 0, -32768, 0));
		send_request(make_item(FUNC_WEIGHT, 1, 0, 32767, 0));
		send_request(make_item(FUNC_WEIGHT, 0, 1, -32768, 0));
		send_request(make_item(FUNC_WEIGHT, 1, 1, -32768, 0));
		for (int c = 2; c < MaxOrder; c++) begin
			send_request(make_item(FUNC_WEIGHT, 0, c, 0, 0));
			send_request(make_item(FUNC_WEIGHT, 1, c, 0, 0));
		end
		send_request(make_item(FUNC_SINGULAR, 0, 0, 1, 0));
		send_request(make_item(FUNC_SINGULAR, 0, 1, 0, 0));
		send_request(make_item(FUNC_SAMPLE, 0, 0, -32768, 0));
		send_request(make_item(FUNC_SAMPLE, 0, 0, -32768, 1));
		send_request(make_item(FUNC_SAMPLE, 0, 0, 32767, 1));
		write_register(REG_INPUT_COUNT, 1);
		write_register(REG_ORDER_IN_USE, 0);
		send_request(make_item(FUNC_SINGULAR, 0, 0, 65535, 0));
		send_request(make_item(FUNC_SAMPLE, 0, 0, 32767, 1));

		// Random phases over several register settings; rows 0..5 cover the
		// longest vectors sent, so no sample reads an unloaded weight
		sizes = '{3, 4, 1, 2};
		foreach (sizes[p]) begin
			write_register(REG_INPUT_COUNT, sizes[p]);
			write_register(REG_ORDER_IN_USE, p == 1 ? 31 : $urandom_range(0, 16));
			load_all(p == 0 ? 2 : 0, p == 0 ? 6 : 0, p != 1);
			for (int v = 0; v < 10; v++)
				send_vector($urandom_range(0, 4) == 0 ?
					$urandom_range(1, sizes[p] + 2) : sizes[p]);
		end

		// Oversized count acts as the maximum; short vectors come back as errors
		write_register(REG_INPUT_COUNT, 127);
		for (int v = 0; v < 2; v++)
			send_vector($urandom_range(1, 4));

		in_ch.valid <= 1'b0;
		while (coefficient_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end
endmodule

// ===== files.f =====
design/svdp_pkg.sv
design/svdp_if.sv
design/svdp_cell.sv
design/svdp_divider.sv
design/svd_projection_engine.sv
dv/testbench.sv
